[rtl/core/lcd_scan_controller_top_defines.svh]
// Assertion macros used by the checker file of the LCD scan controller.
`ifndef LCD_SCAN_CONTROLLER_TOP_DEFINES_SVH
`define LCD_SCAN_CONTROLLER_TOP_DEFINES_SVH

// A property sampled on the rising clock edge, ignored while reset is low.
`define LCDSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication sampled on the rising clock edge, ignored while reset is low.
`define LCDSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/lcdsc_pkg.sv]
`timescale 1ns / 1ps

package lcdsc_pkg;

    localparam int ROWS_PER_PAGE = 32;
    localparam int BYTES_PER_ROW = 15;
    localparam int SCREEN_BYTES  = 960;

    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 4;
    localparam int PIXROW_W = ROW_W + 1;

    localparam logic [WORD_W-1:0] CONFIG_INIT  = 16'h0000;
    localparam logic [WORD_W-1:0] RAM_END_INIT = 16'hFFFF;
    localparam logic [BYTE_W-1:0] DARK_BYTE    = 8'hFF;

    localparam logic [WORD_W-1:0] INDEX_STEP      = 16'd2;
    localparam logic [WORD_W-1:0] PAGE_STEP_BACK  = WORD_W'(SCREEN_BYTES - 1);
    localparam logic [COL_W-1:0]  LAST_COLUMN     = COL_W'(BYTES_PER_ROW - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW        = ROW_W'(ROWS_PER_PAGE - 1);

    localparam int OFS_SEL_BIT = 1;
    localparam int OFS_HI_BIT  = 0;

    typedef enum logic [1:0] {
        MODE_BUS_READ  = 2'd0,
        MODE_BUS_WRITE = 2'd1,
        MODE_SCAN      = 2'd2,
        MODE_FRAME     = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]        mode;
        logic [1:0]        offset;
        logic              byte_access;
        logic [WORD_W-1:0] write_data;
        logic [BYTE_W-1:0] ram_byte;
    } t_in_item;

    typedef struct packed {
        logic              valid;
        logic              take;
        t_in_item          item;
    } t_stage_ctrl;

    typedef struct packed {
        logic [WORD_W-1:0]   read_data;
        logic [WORD_W-1:0]   fetch_address;
        logic [PIXROW_W-1:0] pixel_row;
        logic [COL_W-1:0]    byte_column;
        logic [BYTE_W-1:0]   dark_bits;
        logic                pixel_valid;
        logic                frame_done;
    } t_out_item;

endpackage

[rtl/core/lcdsc_req_if.sv]
`timescale 1ns / 1ps

interface lcdsc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [1:0]  offset;
    logic        byte_access;
    logic [15:0] write_data;
    logic [7:0]  ram_byte;

    modport source (output valid, mode, offset, byte_access, write_data, ram_byte,
                    input ready);
    modport sink (input valid, mode, offset, byte_access, write_data, ram_byte,
                  output ready);
endinterface

[rtl/core/lcdsc_rsp_if.sv]
`timescale 1ns / 1ps

interface lcdsc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [15:0] fetch_address;
    logic [5:0]  pixel_row;
    logic [3:0]  byte_column;
    logic [7:0]  dark_bits;
    logic        pixel_valid;
    logic        frame_done;

    modport source (output valid, read_data, fetch_address, pixel_row, byte_column,
                    dark_bits, pixel_valid, frame_done, input ready);
    modport sink (input valid, read_data, fetch_address, pixel_row, byte_column,
                  dark_bits, pixel_valid, frame_done, output ready);
endinterface

[rtl/core/lcdsc_cfg_if.sv]
`timescale 1ns / 1ps

interface lcdsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/core/lcdsc_in_reg.sv]
`timescale 1ns / 1ps

module lcdsc_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lcdsc_req_if.sink            i_req,
    input  logic                 i_take,
    output lcdsc_pkg::t_stage_ctrl o_ctrl
);
    import lcdsc_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_accept;

    assign i_req.ready = !r_valid || i_take;
    assign w_accept    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.mode        <= i_req.mode;
            r_item.offset      <= i_req.offset;
            r_item.byte_access <= i_req.byte_access;
            r_item.write_data  <= i_req.write_data;
            r_item.ram_byte    <= i_req.ram_byte;
        end
    end

    always_comb begin
        o_ctrl.valid = r_valid;
        o_ctrl.take  = i_take;
        o_ctrl.item  = r_item;
    end
endmodule

[rtl/core/lcdsc_bus_regs.sv]
`timescale 1ns / 1ps

module lcdsc_bus_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcdsc_pkg::t_stage_ctrl        i_ctrl,
    output logic [lcdsc_pkg::WORD_W-1:0]  o_base,
    output logic [lcdsc_pkg::WORD_W-1:0]  o_read_data
);
    import lcdsc_pkg::*;

    logic [WORD_W-1:0] r_base;
    logic [WORD_W-1:0] r_config;
    logic [WORD_W-1:0] n_base;
    logic [WORD_W-1:0] n_config;
    logic [WORD_W-1:0] w_word;
    logic [WORD_W-1:0] w_merged;
    logic              w_sel;
    logic              w_hi;

    always_comb begin
        w_sel = i_ctrl.item.offset[OFS_SEL_BIT];
        w_hi  = i_ctrl.item.offset[OFS_HI_BIT];
        w_word = w_sel ? r_config : r_base;

        o_read_data = '0;
        if (t_mode'(i_ctrl.item.mode) == MODE_BUS_READ) begin
            if (i_ctrl.item.byte_access) begin
                o_read_data = w_hi ? {8'h00, w_word[15:8]} : {8'h00, w_word[7:0]};
            end else begin
                o_read_data = w_word;
            end
        end

        if (i_ctrl.item.byte_access) begin
            w_merged = w_hi ? {i_ctrl.item.write_data[7:0], w_word[7:0]}
                            : {w_word[15:8], i_ctrl.item.write_data[7:0]};
        end else begin
            w_merged = i_ctrl.item.write_data;
        end

        n_base   = r_base;
        n_config = r_config;
        if (i_ctrl.take && t_mode'(i_ctrl.item.mode) == MODE_BUS_WRITE) begin
            if (w_sel) begin
                n_config = w_merged;
            end else begin
                n_base = w_merged;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_config <= CONFIG_INIT;
        end else begin
            r_base   <= n_base;
            r_config <= n_config;
        end
    end

    assign o_base = r_base;
endmodule

[rtl/core/lcdsc_scan_out.sv]
`timescale 1ns / 1ps

module lcdsc_scan_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcdsc_pkg::t_stage_ctrl        i_ctrl,
    input  logic [lcdsc_pkg::WORD_W-1:0]  i_base,
    input  logic [lcdsc_pkg::WORD_W-1:0]  i_read_data,
    lcdsc_cfg_if.sink                     i_cfg,
    lcdsc_rsp_if.source                   o_rsp,
    output logic                          o_take
);
    import lcdsc_pkg::*;

    logic [WORD_W-1:0] r_ram_end;
    logic [WORD_W-1:0] r_frame_base;
    logic              r_page;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [WORD_W-1:0] r_index;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [WORD_W-1:0] n_frame_base;
    logic              n_page;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic [WORD_W-1:0] n_index;
    t_out_item         n_out;
    logic [WORD_W-1:0] w_addr;

    assign i_cfg.ready = 1'b1;
    assign o_take = i_ctrl.valid && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_frame_base = r_frame_base;
        n_page  = r_page;
        n_row   = r_row;
        n_col   = r_col;
        n_index = r_index;
        w_addr  = r_frame_base + r_index;

        n_out.read_data   = i_read_data;
        n_out.pixel_row   = '0;
        n_out.byte_column = '0;
        n_out.dark_bits   = '0;
        n_out.pixel_valid = 1'b0;
        n_out.frame_done  = 1'b0;

        case (t_mode'(i_ctrl.item.mode))
            MODE_FRAME: begin
                n_frame_base = i_base;
                n_page  = 1'b0;
                n_row   = '0;
                n_col   = '0;
                n_index = '0;
            end
            MODE_SCAN: begin
                n_out.pixel_row   = {r_page, r_row};
                n_out.byte_column = r_col;
                n_out.dark_bits   = (w_addr <= r_ram_end) ? i_ctrl.item.ram_byte : DARK_BYTE;
                n_out.pixel_valid = 1'b1;
                n_index = r_index + INDEX_STEP;
                n_col   = r_col + 1'b1;
                if (r_col == LAST_COLUMN) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                    if (r_row == LAST_ROW) begin
                        n_row = '0;
                        if (!r_page) begin
                            n_page  = 1'b1;
                            n_index = r_index + INDEX_STEP - PAGE_STEP_BACK;
                        end else begin
                            n_out.frame_done = 1'b1;
                            n_page  = 1'b0;
                            n_index = '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        n_out.fetch_address = n_frame_base + n_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_end <= RAM_END_INIT;
        end else if (i_cfg.valid) begin
            r_ram_end <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= '0;
            r_page       <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
            r_index      <= '0;
        end else if (o_take) begin
            r_frame_base <= n_frame_base;
            r_page       <= n_page;
            r_row        <= n_row;
            r_col        <= n_col;
            r_index      <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_out.read_data;
    assign o_rsp.fetch_address = r_out.fetch_address;
    assign o_rsp.pixel_row     = r_out.pixel_row;
    assign o_rsp.byte_column   = r_out.byte_column;
    assign o_rsp.dark_bits     = r_out.dark_bits;
    assign o_rsp.pixel_valid   = r_out.pixel_valid;
    assign o_rsp.frame_done    = r_out.frame_done;
endmodule

[rtl/core/lcd_scan_controller_top.sv]
`timescale 1ns / 1ps
// An accepted request passes an input register, then a result register, before its result appears.
// One request per cycle unless o_rsp stalls; the result register reloads in the cycle it is taken.
// A request stalls only while both the input register and the result register hold unconsumed data.
// Reset is synchronous and active low; it clears both valid flags, the bus registers,
// the frame base, the scan counters and sets the RAM end register to all ones.

module lcd_scan_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdsc_req_if.sink   i_req,
    lcdsc_cfg_if.sink   i_cfg,
    lcdsc_rsp_if.source o_rsp
);
    import lcdsc_pkg::*;

    t_stage_ctrl       w_ctrl;
    logic              w_take;
    logic [WORD_W-1:0] w_base;
    logic [WORD_W-1:0] w_read_data;

    lcdsc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (w_take),
        .o_ctrl  (w_ctrl)
    );

    lcdsc_bus_regs u_bus_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_base      (w_base),
        .o_read_data (w_read_data)
    );

    lcdsc_scan_out u_scan_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_base      (w_base),
        .i_read_data (w_read_data),
        .i_cfg       (i_cfg),
        .o_rsp       (o_rsp),
        .o_take      (w_take)
    );
endmodule

[rtl/core/lcdsc_checker.sv]
`timescale 1ns / 1ps
`include "lcd_scan_controller_top_defines.svh"

module lcdsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [15:0] i_read_data,
    input logic [15:0] i_fetch_address,
    input logic [5:0]  i_pixel_row,
    input logic [3:0]  i_byte_column,
    input logic [7:0]  i_dark_bits,
    input logic        i_pixel_valid,
    input logic        i_frame_done
);
    `LCDSC_ASSERT_IMPL(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, ##1 (i_rsp_valid && $stable(i_fetch_address) && $stable(i_dark_bits) && $stable(i_read_data)), "Stalled response changed.")
    `LCDSC_ASSERT_IMPL(a_done_last, i_clk, i_rst_n, i_rsp_valid && i_frame_done, i_pixel_valid && i_pixel_row == 6'd63 && i_byte_column == 4'd14, "Frame end not on the last byte.")
    `LCDSC_ASSERT_IMPL(a_no_pixels, i_clk, i_rst_n, i_rsp_valid && !i_pixel_valid, i_dark_bits == 8'd0 && i_pixel_row == 6'd0 && i_byte_column == 4'd0 && !i_frame_done, "Pixel fields set without pixels.")
    `LCDSC_ASSERT_IMPL(a_scan_no_read, i_clk, i_rst_n, i_rsp_valid && i_pixel_valid, i_read_data == 16'd0, "Read data set on a scan result.")
    `LCDSC_ASSERT_IMPL(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !i_rsp_valid && i_cfg_ready, "Response valid right after reset.")
endmodule

bind lcd_scan_controller_top lcdsc_checker u_lcdsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_ready     (i_cfg.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_read_data     (o_rsp.read_data),
    .i_fetch_address (o_rsp.fetch_address),
    .i_pixel_row     (o_rsp.pixel_row),
    .i_byte_column   (o_rsp.byte_column),
    .i_dark_bits     (o_rsp.dark_bits),
    .i_pixel_valid   (o_rsp.pixel_valid),
    .i_frame_done    (o_rsp.frame_done)
);
